FILE: hw/rtl/seat_occupancy_state_machine_core_macros.svh
// Assertion macros for the seat occupancy core checker.
// Used by seat_occ_checker.sv; expects aclk and aresetn in scope.
`ifndef SEAT_OCCUPANCY_STATE_MACHINE_CORE_MACROS_SVH
`define SEAT_OCCUPANCY_STATE_MACHINE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SEAT_OCC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("seat_occ check failed");

// Next-cycle implication, disabled during reset.
`define SEAT_OCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("seat_occ check failed");

`endif

FILE: hw/rtl/seat_occ_pkg.sv
// Shared types, register indexes and helpers for the seat occupancy core.
// No dependencies.
package seat_occ_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int LIMIT_WIDTH = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW_SAMPLES  = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_IDLE_LIMIT      = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALERT_LIMIT     = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LIGHT_THRESHOLD = 8'd3;

    localparam logic [7:0]  RST_WINDOW_SAMPLES  = 8'd20;
    localparam logic [15:0] RST_IDLE_LIMIT      = 16'd600;
    localparam logic [15:0] RST_ALERT_LIMIT     = 16'd300;
    localparam logic [11:0] RST_LIGHT_THRESHOLD = 12'd3700;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [1:0] {
        OCCUPIED   = 2'd0,
        VACANT     = 2'd1,
        SUSPICIOUS = 2'd2
    } seat_state_t;

    typedef struct packed {
        logic        motion_level;
        logic [11:0] light_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0] seat_state;
        logic       state_changed;
        logic       flag_alert;
        logic       window_closed;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  window_samples;
        logic [15:0] idle_limit;
        logic [15:0] alert_limit;
        logic [11:0] light_threshold;
    } cfg_t;

    // saturating increment
    function automatic count_t sat_inc(input count_t v);
        return (v == {COUNT_WIDTH{1'b1}}) ? v : v + count_t'(1);
    endfunction

    function automatic logic count_ge(input count_t v, input logic [LIMIT_WIDTH-1:0] lim);
        return CMP_WIDTH'(v) >= CMP_WIDTH'(lim);
    endfunction

endpackage

FILE: hw/rtl/seat_occupancy_state_machine_core.sv
// Top level of the seat occupancy core: input register, step logic, result register.
// Depends on seat_occ_pkg, seat_occ_cfg_regs, seat_occ_step.
//
//  channel   ports                           payload
//  input     s_valid / s_ready / s_data      in_item_t  (motion, light)
//  result    m_valid / m_ready / m_data      out_item_t (state, changed, flag, closed)
//  config    cfg_valid / cfg_ready           cfg_index, cfg_data
//
//  One result per sample; one sample per cycle sustained while m_ready stays high, passing
//  through the input register, then the result register written as the state updates.
//  A stalled result holds; the input register still takes one more transaction.
//  Synchronous active-low reset restores register defaults and a vacant seat.
//  cfg_ready is always high.
module seat_occupancy_state_machine_core (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  seat_occ_pkg::in_item_t                  s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output seat_occ_pkg::out_item_t                 m_data,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [seat_occ_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [seat_occ_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    seat_occ_pkg::cfg_t      cfg;
    seat_occ_pkg::in_item_t  in_data_reg;
    logic                    in_valid_reg;
    seat_occ_pkg::out_item_t out_data_reg;
    logic                    out_valid_reg;
    seat_occ_pkg::out_item_t step_result;
    logic                    advance;

    assign cfg_ready = 1'b1;

    seat_occ_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    seat_occ_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: hw/rtl/seat_occ_cfg_regs.sv
// Configuration register file for the seat occupancy core.
// Depends on seat_occ_pkg.
module seat_occ_cfg_regs (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    wr_en,
    input  logic [seat_occ_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [seat_occ_pkg::CFG_DATA_WIDTH-1:0]  wr_data,
    output seat_occ_pkg::cfg_t                      cfg
);

    seat_occ_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_samples  <= seat_occ_pkg::RST_WINDOW_SAMPLES;
            cfg_reg.idle_limit      <= seat_occ_pkg::RST_IDLE_LIMIT;
            cfg_reg.alert_limit     <= seat_occ_pkg::RST_ALERT_LIMIT;
            cfg_reg.light_threshold <= seat_occ_pkg::RST_LIGHT_THRESHOLD;
        end else if (wr_en) begin
            case (wr_index)
                seat_occ_pkg::REG_WINDOW_SAMPLES:  cfg_reg.window_samples  <= wr_data[7:0];
                seat_occ_pkg::REG_IDLE_LIMIT:      cfg_reg.idle_limit      <= wr_data[15:0];
                seat_occ_pkg::REG_ALERT_LIMIT:     cfg_reg.alert_limit     <= wr_data[15:0];
                seat_occ_pkg::REG_LIGHT_THRESHOLD: cfg_reg.light_threshold <= wr_data[11:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/seat_occ_step.sv
// Window and occupancy state machine: holds the seat state and counters,
// computes one result per step. Depends on seat_occ_pkg.
module seat_occ_step (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step_en,
    input  seat_occ_pkg::in_item_t   item,
    input  seat_occ_pkg::cfg_t       cfg,
    output seat_occ_pkg::out_item_t  result
);

    logic [7:0]                  sample_count_reg, sample_count_next;
    logic                        motion_seen_reg, motion_seen_next;
    seat_occ_pkg::seat_state_t   occ_reg, occ_next;
    seat_occ_pkg::count_t        idle_count_reg, idle_count_next;
    seat_occ_pkg::count_t        alert_count_reg, alert_count_next;

    logic [8:0] count_inc;
    logic       closed;
    logic       seen;
    logic       changed;
    logic       flag;

    assign count_inc = {1'b0, sample_count_reg} + 9'd1;
    // window of zero behaves like one
    assign closed    = count_inc >= {1'b0, cfg.window_samples};
    assign seen      = motion_seen_reg | item.motion_level;

    // next state
    always_comb begin
        sample_count_next = count_inc[7:0];
        motion_seen_next  = seen;
        occ_next          = occ_reg;
        idle_count_next   = idle_count_reg;
        alert_count_next  = alert_count_reg;
        changed           = 1'b0;
        flag              = 1'b0;
        if (closed) begin
            sample_count_next = '0;
            motion_seen_next  = 1'b0;
            if (seen) begin
                if (occ_next != seat_occ_pkg::OCCUPIED) begin
                    occ_next = seat_occ_pkg::OCCUPIED;
                    changed  = 1'b1;
                end
                idle_count_next  = '0;
                alert_count_next = '0;
            end else if (occ_next == seat_occ_pkg::OCCUPIED) begin
                idle_count_next = seat_occ_pkg::sat_inc(idle_count_next);
            end

            // light check; a zero limit fires even right after motion
            if (seat_occ_pkg::count_ge(idle_count_next, cfg.idle_limit) &&
                occ_next == seat_occ_pkg::OCCUPIED) begin
                if (item.light_level > cfg.light_threshold) begin
                    occ_next         = seat_occ_pkg::SUSPICIOUS;
                    alert_count_next = '0;
                end else begin
                    occ_next = seat_occ_pkg::VACANT;
                end
                changed = 1'b1;
            end

            if (occ_next == seat_occ_pkg::SUSPICIOUS) begin
                alert_count_next = seat_occ_pkg::sat_inc(alert_count_next);
                if (seat_occ_pkg::count_ge(alert_count_next, cfg.alert_limit)) begin
                    flag             = 1'b1;
                    alert_count_next = '0;
                end
            end
        end
    end

    // outputs
    always_comb begin
        result.seat_state    = occ_next;
        result.state_changed = changed;
        result.flag_alert    = flag;
        result.window_closed = closed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= '0;
            motion_seen_reg  <= 1'b0;
            occ_reg          <= seat_occ_pkg::VACANT;
            idle_count_reg   <= '0;
            alert_count_reg  <= '0;
        end else if (step_en) begin
            sample_count_reg <= sample_count_next;
            motion_seen_reg  <= motion_seen_next;
            occ_reg          <= occ_next;
            idle_count_reg   <= idle_count_next;
            alert_count_reg  <= alert_count_next;
        end
    end

endmodule

FILE: hw/rtl/seat_occ_checker.sv
// Port-level checks for the seat occupancy core, bound to the top level.
// Depends on seat_occ_pkg and seat_occupancy_state_machine_core_macros.svh.
`include "seat_occupancy_state_machine_core_macros.svh"

module seat_occ_checker (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input seat_occ_pkg::out_item_t m_data
);

    // status and flag only move at a window close
    `SEAT_OCC_ASSERT(a_quiet_mid_window, m_valid && !m_data.window_closed |-> !m_data.state_changed && !m_data.flag_alert)

    `SEAT_OCC_ASSERT(a_state_code, m_valid |-> m_data.seat_state != 2'd3)

    // a flag pulse is only issued while suspicious
    `SEAT_OCC_ASSERT(a_flag_suspicious, m_valid && m_data.flag_alert |-> m_data.seat_state == seat_occ_pkg::SUSPICIOUS)

    `SEAT_OCC_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule

bind seat_occupancy_state_machine_core seat_occ_checker u_seat_occ_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
